/* src/endpoint_circuit_breaker_assert.svh */
// ----------------------------------------------------------------------------
// endpoint circuit breaker assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ENDPOINT_CIRCUIT_BREAKER_ASSERT_SVH
`define ENDPOINT_CIRCUIT_BREAKER_ASSERT_SVH

// same-cycle implication
`define CB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define CB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* src/cb_pkg.sv */
// ----------------------------------------------------------------------------
// cb_pkg
// Types, codes and constants shared by the endpoint circuit breaker files.
// ----------------------------------------------------------------------------
`default_nettype none

package cb_pkg;

  localparam int NUM_ENDPOINTS_DEF = 64;
  localparam int WINDOW_MAX        = 64;
  localparam int TIME_BITS         = 48;
  localparam int IDX_BITS          = 6;
  localparam int WFILL_BITS        = 7;
  localparam int CFG_DATA_BITS     = 32;
  localparam int CFG_IDX_BITS      = 3;

  typedef enum logic [1:0] {
    REQ_ACQUIRE  = 2'd0,
    REQ_COMPLETE = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_RESET    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_HTTP       = 3'd1,
    ERR_RATE_LIM   = 3'd2,
    ERR_CIRC_OPEN  = 3'd3,
    ERR_OTHER      = 3'd4,
    ERR_NO_RESULT  = 3'd5,
    ERR_RSVD6      = 3'd6,
    ERR_RSVD7      = 3'd7
  } err_class_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENABLED     = 3'd0,
    CFG_COOLDOWN    = 3'd1,
    CFG_PROBE_LIMIT = 3'd2,
    CFG_WIN_LEN     = 3'd3,
    CFG_CONSEC      = 3'd4,
    CFG_RATE        = 3'd5,
    CFG_MIN_SAMPLES = 3'd6,
    CFG_NONE        = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_TRIM = 2'd2,
    ST_EXEC = 2'd3
  } cb_state_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [IDX_BITS-1:0]  endpoint_index;
    logic [TIME_BITS-1:0] now_time;
    logic [2:0]           error_class;
    logic [9:0]           status_code;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [1:0] breaker_state;
  } rsp_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [TIME_BITS-1:0]  open_stamp;
    logic [7:0]            probes_active;
    logic [15:0]           fail_streak;
    logic [WINDOW_MAX-1:0] window_bits;
    logic [WFILL_BITS-1:0] window_fill;
    logic [WFILL_BITS-1:0] window_failures;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

`default_nettype wire

/* src/cb_table.sv */
// ----------------------------------------------------------------------------
// cb_table
// Per-endpoint breaker table: one synchronous memory with registered read
// and a valid bit per entry, so that reset clears the whole table at once.
// ----------------------------------------------------------------------------
`default_nettype none

module cb_table #(
  parameter int NUM_ENDPOINTS = cb_pkg::NUM_ENDPOINTS_DEF,
  parameter int AW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output cb_pkg::entry_t       rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  cb_pkg::entry_t       wr_data
);

  cb_pkg::entry_t             mem [NUM_ENDPOINTS];
  logic [NUM_ENDPOINTS-1:0]   vld;
  cb_pkg::entry_t             rd_raw;
  logic                       rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

`default_nettype wire

/* src/endpoint_circuit_breaker.sv */
// ----------------------------------------------------------------------------
// endpoint_circuit_breaker
// Table of closed / open / half-open breakers, one per backend endpoint.
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid, req_stall, req) carries acquire, completion,
//   query and endpoint reset items; rsp channel (rsp_valid, rsp_stall, rsp)
//   returns one result per item: granted flag and state after the item.
//   config registers are written through cfg_we / cfg_addr / cfg_data. The
//   user must write them while the block is idle; it does not check this.
// sequencing:
//   one item at a time: after the input transfer the item passes through
//   table read, window trim with failure count, update and write back,
//   then the block returns to idle before it takes the next item.
// reset:
//   rst clears every entry at once through per-entry valid bits and loads
//   the default register values; no clearing pass is needed.
// stall:
//   the result register holds while rsp_stall is high; a new item is taken
//   meanwhile and waits in the update step until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "endpoint_circuit_breaker_assert.svh"

module endpoint_circuit_breaker #(
  parameter int NUM_ENDPOINTS = cb_pkg::NUM_ENDPOINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  cb_pkg::req_t                           req,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output cb_pkg::rsp_t                           rsp,
  input  wire logic                              cfg_we,
  input  wire logic [cb_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
  input  wire logic [cb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int AW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
  localparam int WM = cb_pkg::WINDOW_MAX;
  localparam int FB = cb_pkg::WFILL_BITS;

  // config registers
  logic        breaker_enabled;
  logic [31:0] cooldown_ms;
  logic [7:0]  probe_limit;
  logic [6:0]  window_length;
  logic [15:0] consecutive_limit;
  logic [6:0]  rate_percent;
  logic [6:0]  min_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      breaker_enabled   <= 1'b1;
      cooldown_ms       <= 32'd5000;
      probe_limit       <= 8'd1;
      window_length     <= 7'd20;
      consecutive_limit <= 16'd5;
      rate_percent      <= 7'd50;
      min_samples       <= 7'd10;
    end else if (cfg_we) begin
      case (cb_pkg::cfg_reg_t'(cfg_addr))
        cb_pkg::CFG_ENABLED:     breaker_enabled   <= cfg_data[0];
        cb_pkg::CFG_COOLDOWN:    cooldown_ms       <= cfg_data;
        cb_pkg::CFG_PROBE_LIMIT: probe_limit       <= cfg_data[7:0];
        cb_pkg::CFG_WIN_LEN:     window_length     <= cfg_data[6:0];
        cb_pkg::CFG_CONSEC:      consecutive_limit <= cfg_data[15:0];
        cb_pkg::CFG_RATE:        rate_percent      <= cfg_data[6:0];
        cb_pkg::CFG_MIN_SAMPLES: min_samples       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // control
  cb_pkg::cb_state_t state, state_next;
  logic              req_xfer;
  logic              exec_go;

  assign req_xfer = req_valid && !req_stall;
  assign exec_go  = (state == cb_pkg::ST_EXEC) && !(rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cb_pkg::ST_IDLE: if (req_valid) state_next = cb_pkg::ST_READ;
      cb_pkg::ST_READ: state_next = cb_pkg::ST_TRIM;
      cb_pkg::ST_TRIM: state_next = cb_pkg::ST_EXEC;
      cb_pkg::ST_EXEC: if (exec_go) state_next = cb_pkg::ST_IDLE;
      default:         state_next = cb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    case (state)
      cb_pkg::ST_IDLE: req_stall = 1'b0;
      default:         req_stall = 1'b1;
    endcase
  end

  // captured item
  cb_pkg::req_t item;
  logic [AW-1:0] addr;
  logic          in_range;

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      item <= req;
    end
  end

  assign addr     = AW'(item.endpoint_index);
  assign in_range = 32'(item.endpoint_index) < NUM_ENDPOINTS;

  // table
  cb_pkg::entry_t rd_data;
  cb_pkg::entry_t wr_data;
  logic           tbl_wr_en;

  cb_table #(
    .NUM_ENDPOINTS (NUM_ENDPOINTS),
    .AW            (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == cb_pkg::ST_READ),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (addr),
    .wr_data (wr_data)
  );

  // trim step: drop oldest results, count failures, test cool-down
  logic [FB-1:0]  win_len;
  logic [FB-1:0]  keep;
  logic [WM-1:0]  kept_bits;
  logic [FB-1:0]  kept_fails;
  logic           expired;
  logic [cb_pkg::TIME_BITS-1:0] elapsed;

  cb_pkg::entry_t ent;
  logic [WM-1:0]  ent_bits;
  logic [FB-1:0]  ent_keep;
  logic [FB-1:0]  ent_fails;
  logic           ent_expired;

  always_comb begin
    if (window_length == '0) begin
      win_len = FB'(1);
    end else if (32'(window_length) > WM) begin
      win_len = FB'(WM);
    end else begin
      win_len = window_length;
    end
    keep = (rd_data.window_fill >= win_len) ? win_len - FB'(1) : rd_data.window_fill;
    for (int i = 0; i < WM; i++) begin
      kept_bits[i] = rd_data.window_bits[i] && (FB'(i) < keep);
    end
    kept_fails = '0;
    for (int i = 0; i < WM; i++) begin
      kept_fails = kept_fails + FB'(kept_bits[i]);
    end
    elapsed = item.now_time - rd_data.open_stamp;
    expired = (item.now_time >= rd_data.open_stamp) &&
              (elapsed >= cb_pkg::TIME_BITS'(cooldown_ms));
  end

  always_ff @(posedge clk) begin
    if (state == cb_pkg::ST_TRIM) begin
      ent         <= rd_data;
      ent_bits    <= kept_bits;
      ent_keep    <= keep;
      ent_fails   <= kept_fails;
      ent_expired <= expired;
    end
  end

  // update step
  logic          fail;
  logic [7:0]    lim;
  logic [15:0]   streak_new;
  logic [FB-1:0] fill_new;
  logic [FB-1:0] fails_new;
  logic [13:0]   fail_pct;
  logic [13:0]   rate_fill;
  logic          granted;
  logic          do_write;
  cb_pkg::entry_t upd;

  always_comb begin
    case (cb_pkg::err_class_t'(item.error_class))
      cb_pkg::ERR_OK, cb_pkg::ERR_RATE_LIM, cb_pkg::ERR_CIRC_OPEN: fail = 1'b0;
      cb_pkg::ERR_HTTP: fail = item.status_code >= 10'd500;
      default:          fail = 1'b1;
    endcase
    lim        = (probe_limit == '0) ? 8'd1 : probe_limit;
    streak_new = fail ? ((ent.fail_streak == 16'hFFFF) ? ent.fail_streak
                                                       : ent.fail_streak + 16'd1)
                      : 16'd0;
    fill_new   = ent_keep + FB'(1);
    fails_new  = ent_fails + FB'(fail);
    fail_pct   = 14'(fails_new) * 14'd100;
    rate_fill  = 14'(rate_percent) * 14'(fill_new);

    upd      = ent;
    granted  = 1'b1;
    do_write = 1'b0;
    if (!in_range) begin
      upd = '0;
    end else if (item.req_type == cb_pkg::REQ_RESET) begin
      upd      = '0;
      do_write = 1'b1;
    end else if (breaker_enabled) begin
      do_write = 1'b1;
      case (cb_pkg::req_kind_t'(item.req_type))
        cb_pkg::REQ_ACQUIRE: begin
          if (ent.mode == cb_pkg::MODE_OPEN) begin
            if (!ent_expired) begin
              granted = 1'b0;
            end else begin
              upd.mode          = cb_pkg::MODE_HALF;
              upd.probes_active = '0;
            end
          end
          if (granted && upd.mode == cb_pkg::MODE_HALF) begin
            if (upd.probes_active >= lim) begin
              granted = 1'b0;
            end else begin
              upd.probes_active = upd.probes_active + 8'd1;
            end
          end
        end
        cb_pkg::REQ_COMPLETE: begin
          if (ent.mode == cb_pkg::MODE_HALF) begin
            if (fail) begin
              upd.mode          = cb_pkg::MODE_OPEN;
              upd.open_stamp    = item.now_time;
              upd.probes_active = '0;
            end else begin
              upd = '0;
            end
          end else if (ent.mode == cb_pkg::MODE_CLOSED) begin
            upd.window_bits     = (ent_bits << 1) | WM'(fail);
            upd.window_fill     = fill_new;
            upd.window_failures = fails_new;
            upd.fail_streak     = streak_new;
            if ((consecutive_limit != '0 && streak_new >= consecutive_limit) ||
                (rate_percent != '0 && fill_new >= min_samples &&
                 fail_pct >= rate_fill)) begin
              upd.mode          = cb_pkg::MODE_OPEN;
              upd.open_stamp    = item.now_time;
              upd.probes_active = '0;
            end
          end
        end
        default: ;
      endcase
    end else begin
      upd = '0;
    end
  end

  assign tbl_wr_en = exec_go && do_write;
  assign wr_data   = upd;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp.granted       <= granted;
      rsp.breaker_state <= upd.mode;
    end
  end

  `CB_ASSERT_IMP(a_xfer_idle, req_xfer, state == cb_pkg::ST_IDLE)
  `CB_ASSERT_NEXT(a_xfer_read, req_xfer, state == cb_pkg::ST_READ)
  `CB_ASSERT_IMP(a_write_exec, tbl_wr_en, state == cb_pkg::ST_EXEC)
  `CB_ASSERT_NEXT(a_exec_result, exec_go, rsp_valid)

endmodule

`default_nettype wire

/* tb/tb_endpoint_circuit_breaker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_endpoint_circuit_breaker
// Drives acquire, completion, query and endpoint reset transfers into the
// breaker table under random idling and a long result hold-off, predicts each
// result with a scoreboard that keeps its own copy of the table, and checks
// every result in order across several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_endpoint_circuit_breaker;
  import cb_pkg::*;

  class breaker_scoreboard;
    logic        enabled;
    logic [31:0] cooldown;
    logic [7:0]  probe_lim;
    logic [6:0]  win_len;
    logic [15:0] consec_lim;
    logic [6:0]  rate_pct;
    logic [6:0]  min_samp;
    mode_t       mode_q [64];
    logic [47:0] stamp_q [64];
    int unsigned probes_q [64];
    int unsigned streak_q [64];
    logic [63:0] bits_q [64];
    int unsigned fill_q [64];
    int unsigned fails_q [64];
    rsp_t        pending [$];
    int          errors;

    function void clear_endpoint(int e);
      mode_q[e] = MODE_CLOSED;
      stamp_q[e] = '0;
      probes_q[e] = 0;
      streak_q[e] = 0;
      bits_q[e] = '0;
      fill_q[e] = 0;
      fails_q[e] = 0;
    endfunction

    function void reset_all();
      enabled = 1'b1;
      cooldown = 32'd5000;
      probe_lim = 8'd1;
      win_len = 7'd20;
      consec_lim = 16'd5;
      rate_pct = 7'd50;
      min_samp = 7'd10;
      for (int e = 0; e < 64; e++) clear_endpoint(e);
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t a, logic [31:0] d);
      case (a)
        CFG_ENABLED: enabled = d[0];
        CFG_COOLDOWN: cooldown = d;
        CFG_PROBE_LIMIT: probe_lim = d[7:0];
        CFG_WIN_LEN: win_len = d[6:0];
        CFG_CONSEC: consec_lim = d[15:0];
        CFG_RATE: rate_pct = d[6:0];
        CFG_MIN_SAMPLES: min_samp = d[6:0];
        default: ;
      endcase
    endfunction

    function void open_breaker(int e, logic [47:0] now);
      mode_q[e] = MODE_OPEN;
      stamp_q[e] = now;
      probes_q[e] = 0;
    endfunction

    function void record_result(int e, bit fail, logic [47:0] now);
      int unsigned len;
      len = win_len;
      if (len == 0) len = 1;
      if (len > 64) len = 64;
      while (fill_q[e] >= len && fill_q[e] > 0) begin
        if (bits_q[e][fill_q[e]-1]) begin
          bits_q[e][fill_q[e]-1] = 1'b0;
          if (fails_q[e] > 0) fails_q[e]--;
        end
        fill_q[e]--;
      end
      bits_q[e] = {bits_q[e][62:0], fail};
      fill_q[e]++;
      if (fail) begin
        fails_q[e]++;
        if (streak_q[e] < 65535) streak_q[e]++;
      end else begin
        streak_q[e] = 0;
      end
      if (consec_lim > 0 && streak_q[e] >= consec_lim) begin
        open_breaker(e, now);
        return;
      end
      if (rate_pct == 0 || fill_q[e] < min_samp) return;
      if (longint'(fails_q[e]) * 100 >= longint'(rate_pct) * fill_q[e])
        open_breaker(e, now);
    endfunction

    function void note_request(req_t r);
      rsp_t x;
      int e;
      bit fail;
      int unsigned lim;
      e = r.endpoint_index;
      x.granted = 1'b1;
      x.breaker_state = MODE_CLOSED;
      if (r.req_type == REQ_RESET) begin
        clear_endpoint(e);
      end else if (enabled) begin
        if (r.req_type == REQ_ACQUIRE) begin
          if (mode_q[e] == MODE_OPEN) begin
            if (r.now_time < stamp_q[e] || r.now_time - stamp_q[e] < {16'd0, cooldown}) begin
              x.granted = 1'b0;
            end else begin
              mode_q[e] = MODE_HALF;
              probes_q[e] = 0;
            end
          end
          if (x.granted && mode_q[e] == MODE_HALF) begin
            lim = probe_lim;
            if (lim == 0) lim = 1;
            if (probes_q[e] >= lim) x.granted = 1'b0;
            else probes_q[e]++;
          end
        end else if (r.req_type == REQ_COMPLETE) begin
          case (r.error_class)
            ERR_OK, ERR_RATE_LIM, ERR_CIRC_OPEN: fail = 0;
            ERR_HTTP: fail = r.status_code >= 10'd500;
            default: fail = 1;
          endcase
          if (mode_q[e] == MODE_HALF) begin
            if (probes_q[e] > 0) probes_q[e]--;
            if (fail) open_breaker(e, r.now_time);
            else clear_endpoint(e);
          end else if (mode_q[e] == MODE_CLOSED) begin
            record_result(e, fail, r.now_time);
          end
        end
        x.breaker_state = mode_q[e];
      end
      pending = {pending, x};
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      exp_r = pending[0];
      pending.delete(0);
      if (got.granted !== exp_r.granted)
        report_mismatch($sformatf("granted got %b exp %b", got.granted, exp_r.granted));
      if (got.breaker_state !== exp_r.breaker_state)
        report_mismatch($sformatf("state got %0d exp %0d", got.breaker_state,
                                  exp_r.breaker_state));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  breaker_scoreboard sb;
  logic [47:0] clock_ms = 48'd1000;
  int cycles = 0;
  bit hold_long = 0;

  endpoint_circuit_breaker dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  // receiver side stalling
  initial begin
    int w;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        rsp_stall <= 1'b1;
        repeat (60) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_long = 0;
      end else begin
        w = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
          rsp_stall <= 1'b1;
          repeat (w - 1) @(posedge clk);
          @(posedge clk);
        end
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic write_cfg(cfg_reg_t a, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(a, d);
    @(posedge clk);
  endtask

  task automatic send_item(req_t r, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 4) : 0;
    if (w > 0) begin
      req_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic end_burst();
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    end_burst();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic req_t make_req(req_kind_t k, int e, logic [47:0] t,
                                    err_class_t c, int s);
    req_t r;
    r.req_type = k;
    r.endpoint_index = IDX_BITS'(e);
    r.now_time = t;
    r.error_class = c;
    r.status_code = 10'(s);
    return r;
  endfunction

  task automatic random_items(int n, int ep_span);
    req_t r;
    int pick;
    for (int i = 0; i < n; i++) begin
      clock_ms = clock_ms + 48'($urandom_range(0, 300));
      r.req_type = $urandom_range(0, 9) < 4 ? REQ_ACQUIRE :
                   ($urandom_range(0, 5) < 4 ? REQ_COMPLETE :
                   ($urandom_range(0, 1) ? REQ_QUERY : REQ_RESET));
      r.endpoint_index = IDX_BITS'($urandom_range(0, ep_span));
      pick = $urandom_range(0, 19);
      r.now_time = pick == 0 ? 48'({$urandom, $urandom}) :
                   (pick == 1 ? clock_ms - 48'($urandom_range(0, 2000)) : clock_ms);
      r.error_class = 3'($urandom_range(0, 7));
      r.status_code = 10'($urandom_range(0, 1023));
      send_item(r, i % 50 < 40);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_all();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with reset defaults
    send_item(make_req(REQ_QUERY, 0, 48'd0, ERR_OK, 0), 0);
    for (int i = 0; i < 5; i++)
      send_item(make_req(REQ_COMPLETE, 63, 48'd100, ERR_OTHER, 0), 0);
    send_item(make_req(REQ_ACQUIRE, 63, 48'd50, ERR_OK, 0), 0);
    send_item(make_req(REQ_ACQUIRE, 63, 48'd5099, ERR_OK, 0), 0);
    send_item(make_req(REQ_ACQUIRE, 63, 48'd5100, ERR_OK, 0), 0);
    send_item(make_req(REQ_ACQUIRE, 63, 48'd5101, ERR_OK, 0), 0);
    send_item(make_req(REQ_COMPLETE, 63, 48'd5200, ERR_HTTP, 500), 0);
    send_item(make_req(REQ_COMPLETE, 63, 48'd5200, ERR_OK, 0), 0);
    send_item(make_req(REQ_ACQUIRE, 63, 48'hFFFF_FFFF_FFFF, ERR_OK, 0), 0);
    send_item(make_req(REQ_COMPLETE, 63, 48'd0, ERR_HTTP, 1023), 0);
    send_item(make_req(REQ_COMPLETE, 63, 48'd0, ERR_OK, 0), 0);
    send_item(make_req(REQ_COMPLETE, 1, 48'd0, ERR_HTTP, 499), 0);
    send_item(make_req(REQ_COMPLETE, 1, 48'd0, ERR_RATE_LIM, 0), 0);
    send_item(make_req(REQ_COMPLETE, 1, 48'd0, ERR_CIRC_OPEN, 0), 0);
    send_item(make_req(REQ_COMPLETE, 1, 48'd0, ERR_NO_RESULT, 0), 0);
    send_item(make_req(REQ_COMPLETE, 1, 48'd0, ERR_RSVD6, 0), 0);
    send_item(make_req(REQ_COMPLETE, 1, 48'd0, ERR_RSVD7, 0), 0);
    send_item(make_req(REQ_RESET, 63, 48'd0, ERR_OK, 0), 0);
    send_item(make_req(REQ_QUERY, 63, 48'd0, ERR_OK, 0), 0);
    drain();

    // receiver holds off while the sender keeps offering
    hold_long = 1;
    random_items(30, 7);
    drain();

    // phase: defaults, random
    random_items(80, 7);
    drain();

    // phase: short cooldown, many probes, small window, rate rule only
    write_cfg(CFG_COOLDOWN, 32'd0);
    write_cfg(CFG_PROBE_LIMIT, 32'd3);
    write_cfg(CFG_WIN_LEN, 32'd4);
    write_cfg(CFG_CONSEC, 32'd0);
    write_cfg(CFG_RATE, 32'd100);
    write_cfg(CFG_MIN_SAMPLES, 32'd0);
    random_items(80, 3);
    drain();

    // phase: extremes
    write_cfg(CFG_COOLDOWN, 32'hFFFF_FFFF);
    write_cfg(CFG_PROBE_LIMIT, 32'd0);
    write_cfg(CFG_WIN_LEN, 32'd64);
    write_cfg(CFG_CONSEC, 32'd65535);
    write_cfg(CFG_RATE, 32'd1);
    write_cfg(CFG_MIN_SAMPLES, 32'd64);
    random_items(60, 1);
    drain();

    // phase: window shrink and zero length
    write_cfg(CFG_COOLDOWN, 32'd200);
    write_cfg(CFG_PROBE_LIMIT, 32'd255);
    write_cfg(CFG_WIN_LEN, 32'd0);
    write_cfg(CFG_CONSEC, 32'd3);
    write_cfg(CFG_RATE, 32'd0);
    write_cfg(CFG_MIN_SAMPLES, 32'd1);
    random_items(60, 63);
    drain();

    // phase: breaker disabled, then back on with defaults-like values
    write_cfg(CFG_ENABLED, 32'd0);
    random_items(40, 63);
    drain();
    write_cfg(CFG_ENABLED, 32'd1);
    write_cfg(CFG_WIN_LEN, 32'd10);
    write_cfg(CFG_RATE, 32'd60);
    write_cfg(CFG_MIN_SAMPLES, 32'd5);
    write_cfg(CFG_PROBE_LIMIT, 32'd2);
    random_items(60, 5);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
